### design/mvt_pkg.sv
// shared types and constants for the matrix-vector transform unit
package mvt_pkg;

	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int SUM_W     = PROD_W + 2;
	localparam int MAX_DIM   = 4;
	localparam int IDX_W     = 4;
	localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
	localparam int DIM_DEF   = 4;
	localparam int FRAC_DEF  = 16;

	localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_XFORM = 1'b1
	} mvt_op_t;

	typedef logic signed [DATA_W-1:0] mvt_data_t;
	typedef logic signed [SUM_W-1:0]  mvt_sum_t;

	// pipeline control handed to the merge stage
	typedef struct packed {
		logic en;
		logic vld;
	} mvt_pipe_t;

endpackage

### design/mvt_in_if.sv
// command channel: matrix element loads and vectors to transform
interface mvt_in_if;
	import mvt_pkg::*;

	logic      valid;
	logic      ready;
	mvt_op_t   op;
	logic [IDX_W-1:0] elem_index;
	mvt_data_t elem_value;
	mvt_data_t in_x;
	mvt_data_t in_y;
	mvt_data_t in_z;
	mvt_data_t in_w;

	modport source (
		output valid, op, elem_index, elem_value, in_x, in_y, in_z, in_w,
		input  ready
	);

	modport sink (
		input  valid, op, elem_index, elem_value, in_x, in_y, in_z, in_w,
		output ready
	);

endinterface

### design/mvt_out_if.sv
// result channel: transformed vector and saturation flag
interface mvt_out_if;
	import mvt_pkg::*;

	logic      valid;
	logic      ready;
	mvt_data_t out_x;
	mvt_data_t out_y;
	mvt_data_t out_z;
	mvt_data_t out_w;
	logic      clipped;

	modport source (
		output valid, out_x, out_y, out_z, out_w, clipped,
		input  ready
	);

	modport sink (
		input  valid, out_x, out_y, out_z, out_w, clipped,
		output ready
	);

endinterface

### design/mvt_lane.sv
// one matrix row dotted with the vector: multiply, pair add, final add
module mvt_lane #(
	parameter int DIM = mvt_pkg::DIM_DEF
) (
	input  logic                clk,
	input  logic                en,
	input  mvt_pkg::mvt_data_t  row_elem [mvt_pkg::MAX_DIM],
	input  mvt_pkg::mvt_data_t  vec      [mvt_pkg::MAX_DIM],
	output mvt_pkg::mvt_sum_t   sum_s3
);
	import mvt_pkg::*;

	logic signed [PROD_W-1:0] prod_s1 [MAX_DIM];
	logic signed [PROD_W:0]   pair_s2 [MAX_DIM/2];

	// one 32x32 multiplier per active column, unused columns read as zero
	for (genvar c = 0; c < MAX_DIM; c++) begin : g_col
		if (c < DIM) begin : g_mul
			always_ff @(posedge clk) begin
				if (en) begin
					prod_s1[c] <= PROD_W'(row_elem[c]) * PROD_W'(vec[c]);
				end
			end
		end else begin : g_zero
			assign prod_s1[c] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s2[0] <= (PROD_W+1)'(prod_s1[0]) + (PROD_W+1)'(prod_s1[1]);
			pair_s2[1] <= (PROD_W+1)'(prod_s1[2]) + (PROD_W+1)'(prod_s1[3]);
			sum_s3     <= SUM_W'(pair_s2[0]) + SUM_W'(pair_s2[1]);
		end
	end

endmodule

### design/mvt_merge.sv
// scales and saturates the lane sums, registers the result transfer
module mvt_merge #(
	parameter int FRAC_BITS = mvt_pkg::FRAC_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mvt_pkg::mvt_pipe_t pipe,
	input  mvt_pkg::mvt_sum_t  sum_s3 [mvt_pkg::MAX_DIM],
	mvt_out_if.source          res
);
	import mvt_pkg::*;

	mvt_sum_t  shifted [MAX_DIM];
	mvt_data_t sat_val [MAX_DIM];
	logic [MAX_DIM-1:0] clip;
	logic      valid_q;
	mvt_data_t val_q [MAX_DIM];
	logic      clip_q;

	// floor shift, then clamp when the upper bits are not all sign
	always_comb begin
		for (int r = 0; r < MAX_DIM; r++) begin
			shifted[r] = sum_s3[r] >>> FRAC_BITS;
			clip[r]    = !((&shifted[r][SUM_W-1:DATA_W-1]) ||
				!(|shifted[r][SUM_W-1:DATA_W-1]));
			if (!clip[r]) begin
				sat_val[r] = shifted[r][DATA_W-1:0];
			end else if (shifted[r][SUM_W-1]) begin
				sat_val[r] = SAT_MIN;
			end else begin
				sat_val[r] = SAT_MAX;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pipe.en) begin
			valid_q <= pipe.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe.en) begin
			val_q  <= sat_val;
			clip_q <= |clip;
		end
	end

	assign res.valid   = valid_q;
	assign res.out_x   = val_q[0];
	assign res.out_y   = val_q[1];
	assign res.out_z   = val_q[2];
	assign res.out_w   = val_q[3];
	assign res.clipped = clip_q;

endmodule

### design/matrix_vector_transform_unit.sv
// top level of the 4x4 fixed-point matrix-vector transform unit
//
// cmd channel (valid/ready): op selects a matrix element load or a vector
// transform. a load writes one element of the row-major matrix at
// elem_index and never produces a result. a transform multiplies the
// stored matrix by (in_x, in_y, in_z, in_w), all signed Q16.16.
// res channel (valid/ready): one transfer per transform with out_x..out_w
// and clipped, which is set when any component saturated to 32 bits.
// a transform passes the multiply, pair add and final add registers and
// the scale/saturate output register before its result shows on res. one
// item per cycle is sustained unless res stalls: each row has its own lane
// of four multipliers, so a new load or transform is taken every cycle.
// a load is visible to a transform accepted in the very next cycle.
// when res stalls, the whole pipeline holds and cmd.ready drops; cmd is
// ready whenever the output register is empty or being drained.
// reset clears the matrix to zero and empties the pipeline.
module matrix_vector_transform_unit #(
	parameter int DIM       = mvt_pkg::DIM_DEF,
	parameter int FRAC_BITS = mvt_pkg::FRAC_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mvt_in_if.sink    cmd,
	mvt_out_if.source res
);
	import mvt_pkg::*;

	mvt_data_t mat_q [MAT_DEPTH];
	mvt_data_t vec   [MAX_DIM];
	mvt_sum_t  sum_s3 [MAX_DIM];
	mvt_pipe_t pipe;
	logic      en;
	logic      cmd_take;
	logic      v_s1;
	logic      v_s2;
	logic      v_s3;

	// pipeline advances unless a finished result is waiting on res
	assign en        = !res.valid || res.ready;
	assign cmd.ready = en;
	assign cmd_take  = cmd.valid && en;

	assign vec[0] = cmd.in_x;
	assign vec[1] = cmd.in_y;
	assign vec[2] = cmd.in_z;
	assign vec[3] = cmd.in_w;

	// matrix store, any of the sixteen entries may be loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_DEPTH; i++) begin
				mat_q[i] <= '0;
			end
		end else if (cmd_take && cmd.op == OP_LOAD) begin
			mat_q[cmd.elem_index] <= cmd.elem_value;
		end
	end

	// valid bits follow transforms through the lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= cmd.valid && cmd.op == OP_XFORM;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign pipe.en  = en;
	assign pipe.vld = v_s3;

	// one lane per active row, inactive rows sum to zero and never clip
	for (genvar r = 0; r < MAX_DIM; r++) begin : g_row
		if (r < DIM) begin : g_lane
			mvt_data_t row_elem [MAX_DIM];
			for (genvar c = 0; c < MAX_DIM; c++) begin : g_elem
				assign row_elem[c] = mat_q[r*MAX_DIM + c];
			end
			mvt_lane #(
				.DIM (DIM)
			) u_lane (
				.clk      (clk),
				.en       (en),
				.row_elem (row_elem),
				.vec      (vec),
				.sum_s3   (sum_s3[r])
			);
		end else begin : g_idle
			assign sum_s3[r] = '0;
		end
	end

	mvt_merge #(
		.FRAC_BITS (FRAC_BITS)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.pipe   (pipe),
		.sum_s3 (sum_s3),
		.res    (res)
	);

	// a load never starts a result
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.op == OP_LOAD) |=> !v_s1)
		else $error("load entered the transform pipeline");

	// an accepted transform always enters the first stage
	a_xform_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.op == OP_XFORM) |=> v_s1)
		else $error("accepted transform lost at stage one");

	// a stalled result blocks new commands
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |-> !cmd.ready)
		else $error("command taken while result stalled");

	// the clip flag implies some component sits at a limit
	a_clip_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.clipped) |->
		(res.out_x == SAT_MAX || res.out_x == SAT_MIN ||
		 res.out_y == SAT_MAX || res.out_y == SAT_MIN ||
		 res.out_z == SAT_MAX || res.out_z == SAT_MIN ||
		 res.out_w == SAT_MAX || res.out_w == SAT_MIN))
		else $error("clipped set with no saturated component");

	// stage valids advance in lockstep with the output register
	a_pipe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s3) |=> res.valid)
		else $error("result lost between last stage and output");

endmodule

### bench/mvt_tb_pkg.sv
// command and result types and the result scoreboard for the transform unit bench
package mvt_tb_pkg;
	import mvt_pkg::*;

	typedef struct packed {
		mvt_op_t          op;
		logic [IDX_W-1:0] idx;
		mvt_data_t        value;
		mvt_data_t        x;
		mvt_data_t        y;
		mvt_data_t        z;
		mvt_data_t        w;
	} cmd_item_t;

	typedef struct packed {
		mvt_data_t x;
		mvt_data_t y;
		mvt_data_t z;
		mvt_data_t w;
		logic      clipped;
	} xform_result_t;

	class xform_scoreboard;
		mvt_data_t     coeff[MAT_DEPTH];
		xform_result_t xform_due[$];
		int            dim;
		int            frac;
		int            errors;
		int            results_seen;

		function new(int dim_cfg, int frac_cfg);
			dim = dim_cfg;
			frac = frac_cfg;
			errors = 0;
			results_seen = 0;
			foreach (coeff[i])
				coeff[i] = '0;
		endfunction

		function int pending();
			return xform_due.size();
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $realtime, msg);
			errors++;
		endtask

		// matrix times vector, full-width sums, floor shift, 32-bit saturation
		function xform_result_t transform_vector(mvt_data_t x, mvt_data_t y, mvt_data_t z,
				mvt_data_t w);
			mvt_data_t     vec[MAX_DIM];
			mvt_data_t     comp[MAX_DIM];
			mvt_sum_t      acc;
			mvt_sum_t      scaled;
			xform_result_t r;
			vec = '{x, y, z, w};
			r.clipped = 1'b0;
			for (int row = 0; row < MAX_DIM; row++) begin
				acc = '0;
				for (int col = 0; col < MAX_DIM; col++)
					if (row < dim && col < dim)
						acc += mvt_sum_t'(coeff[row*MAX_DIM + col]) * mvt_sum_t'(vec[col]);
				scaled = acc >>> frac;
				if (row >= dim) begin
					comp[row] = '0;
				end else if (scaled > mvt_sum_t'(SAT_MAX)) begin
					comp[row] = SAT_MAX;
					r.clipped = 1'b1;
				end else if (scaled < mvt_sum_t'(SAT_MIN)) begin
					comp[row] = SAT_MIN;
					r.clipped = 1'b1;
				end else begin
					comp[row] = mvt_data_t'(scaled);
				end
			end
			r.x = comp[0];
			r.y = comp[1];
			r.z = comp[2];
			r.w = comp[3];
			return r;
		endfunction

		function void note_command(cmd_item_t it);
			if (it.op == OP_LOAD)
				coeff[it.idx] = it.value;
			else
				xform_due.push_back(transform_vector(it.x, it.y, it.z, it.w));
		endfunction

		task check_result(xform_result_t got);
			xform_result_t want;
			results_seen++;
			if (xform_due.size() == 0) begin
				report($sformatf("result %0d arrived with no transform outstanding",
					results_seen));
				return;
			end
			want = xform_due.pop_front();
			if (got.x !== want.x)
				report($sformatf("result %0d out_x %h, want %h", results_seen, got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("result %0d out_y %h, want %h", results_seen, got.y, want.y));
			if (got.z !== want.z)
				report($sformatf("result %0d out_z %h, want %h", results_seen, got.z, want.z));
			if (got.w !== want.w)
				report($sformatf("result %0d out_w %h, want %h", results_seen, got.w, want.w));
			if (got.clipped !== want.clipped)
				report($sformatf("result %0d clipped %b, want %b", results_seen, got.clipped,
					want.clipped));
		endtask
	endclass

endpackage

### bench/tb_top.sv
// top-level bench for the matrix-vector transform unit
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mvt_pkg::*;
	import mvt_tb_pkg::*;

	localparam int DIM        = DIM_DEF;
	localparam int FRAC_BITS  = FRAC_DEF;
	localparam int RAND_ITEMS = 500;
	// no transfer on either channel for this long means the block is stuck,
	// as the idle time of a correct run is only gap + stall + pipeline
	localparam int IDLE_LIMIT = 2000;
	// extra wait at the end, once no transform is outstanding
	localparam int DRAIN_CYCLES = 12;

	// Q16.16 one
	localparam mvt_data_t ONE = 32'sh0001_0000;

	logic clk;
	logic arst_n;

	mvt_in_if  cmd_ch();
	mvt_out_if res_ch();

	matrix_vector_transform_unit #(
		.DIM       (DIM),
		.FRAC_BITS (FRAC_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	xform_scoreboard sb;
	xform_result_t   seen;
	int              idle_cycles;
	int              send_run;
	int              take_run;

	// 8 ns clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// wait length for one item is drawn at random, but now and then a run of
	// back-to-back items so full-rate streaming gets exercised too
	function automatic int draw_wait(inout int run_left);
		if (run_left > 0) begin
			run_left--;
			return 0;
		end
		if ($urandom_range(0, 19) == 0)
			run_left = $urandom_range(10, 40);
		return $urandom_range(0, 15);
	endfunction

	// fixed-point operand: extremes, zero, any bit pattern, or a small
	// magnitude (within +-4.0) so sums mostly stay in range
	function automatic mvt_data_t rand_fixed();
		mvt_data_t v;
		case ($urandom_range(0, 9))
			0: v = SAT_MAX;
			1: v = SAT_MIN;
			2: v = '0;
			3, 4, 5: v = $urandom;
			default: begin
				v = $urandom_range(0, 524287);
				v = v - 262144;
			end
		endcase
		return v;
	endfunction

	// element load; vector fields are don't-care, so fill them with noise
	function automatic cmd_item_t load_cmd(logic [IDX_W-1:0] idx, mvt_data_t value);
		cmd_item_t it;
		it.op = OP_LOAD;
		it.idx = idx;
		it.value = value;
		it.x = $urandom;
		it.y = $urandom;
		it.z = $urandom;
		it.w = $urandom;
		return it;
	endfunction

	// vector transform; element fields are don't-care
	function automatic cmd_item_t xform_cmd(mvt_data_t x, mvt_data_t y, mvt_data_t z,
			mvt_data_t w);
		cmd_item_t it;
		it.op = OP_XFORM;
		it.idx = IDX_W'($urandom_range(0, MAT_DEPTH - 1));
		it.value = $urandom;
		it.x = x;
		it.y = y;
		it.z = z;
		it.w = w;
		return it;
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer.
	// valid is only lowered when a gap follows, so it never drops and rises
	// in the same step
	task send_cmd(cmd_item_t it);
		int gap;
		gap = draw_wait(send_run);
		if (gap != 0) begin
			cmd_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.op         = it.op;
		cmd_ch.elem_index = it.idx;
		cmd_ch.elem_value = it.value;
		cmd_ch.in_x       = it.x;
		cmd_ch.in_y       = it.y;
		cmd_ch.in_z       = it.z;
		cmd_ch.in_w       = it.w;
		cmd_ch.valid      = 1'b1;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		@(negedge clk);
	endtask

	// result side: random back-pressure before every transfer
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		take_run = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = draw_wait(take_run);
			if (stall != 0) begin
				res_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ch.ready = 1'b1;
			do
				@(posedge clk);
			while (!(res_ch.valid && res_ch.ready));
			@(negedge clk);
		end
	end

	// monitors and watchdog: both channels sampled at the rising edge, before
	// the block's registers update
	always @(posedge clk) begin
		if (!arst_n) begin
			idle_cycles = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready)
				sb.note_command(cmd_ch.op == OP_LOAD ?
					load_cmd(cmd_ch.elem_index, cmd_ch.elem_value) :
					xform_cmd(cmd_ch.in_x, cmd_ch.in_y, cmd_ch.in_z, cmd_ch.in_w));
			if (res_ch.valid && res_ch.ready) begin
				seen.x       = res_ch.out_x;
				seen.y       = res_ch.out_y;
				seen.z       = res_ch.out_z;
				seen.w       = res_ch.out_w;
				seen.clipped = res_ch.clipped;
				sb.check_result(seen);
			end
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				sb.report($sformatf("no transfer for %0d cycles, %0d results outstanding",
					IDLE_LIMIT, sb.pending()));
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		sb = new(DIM, FRAC_BITS);
		send_run = 0;
		arst_n = 1'b0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.op         = OP_LOAD;
		cmd_ch.elem_index = '0;
		cmd_ch.elem_value = '0;
		cmd_ch.in_x       = '0;
		cmd_ch.in_y       = '0;
		cmd_ch.in_z       = '0;
		cmd_ch.in_w       = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// matrix is cleared by reset: extreme vector still gives all zeros
		send_cmd(xform_cmd(SAT_MIN, SAT_MAX, -32'sd1, 32'sd1));
		// identity passes the vector through untouched, corner index 0 and 15
		send_cmd(load_cmd(4'd0, ONE));
		send_cmd(load_cmd(4'd5, ONE));
		send_cmd(load_cmd(4'd10, ONE));
		send_cmd(load_cmd(4'd15, ONE));
		send_cmd(xform_cmd(SAT_MIN, SAT_MAX, -32'sd1, 32'sh0001_8000));
		// row 0 = (1, max, 0, 0): large positive sum clips high
		send_cmd(load_cmd(4'd1, SAT_MAX));
		send_cmd(xform_cmd(SAT_MAX, SAT_MAX, '0, '0));
		// row 1 = (min, 1, 0, 0): min times max clips low
		send_cmd(load_cmd(4'd4, SAT_MIN));
		send_cmd(xform_cmd(SAT_MAX, '0, '0, '0));
		// both signs of overflow in one vector, min times min on row 1
		send_cmd(xform_cmd(SAT_MIN, SAT_MIN, '0, '0));
		// one-ulp element: floor rounding of a tiny negative product
		send_cmd(load_cmd(4'd10, 32'sd1));
		send_cmd(xform_cmd('0, '0, -32'sd1, '0));
		send_cmd(xform_cmd('0, '0, 32'sd1, '0));
		// exactly the negative limit does not clip, min times min does
		send_cmd(load_cmd(4'd15, SAT_MIN));
		send_cmd(xform_cmd('0, '0, '0, ONE));
		send_cmd(xform_cmd('0, '0, '0, SAT_MIN));
		// exactly the positive limit does not clip
		send_cmd(load_cmd(4'd15, SAT_MAX));
		send_cmd(xform_cmd('0, '0, '0, ONE));

		// random mix: about a third loads, the rest transforms
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if ($urandom_range(0, 99) < 35)
				send_cmd(load_cmd(IDX_W'($urandom_range(0, MAT_DEPTH - 1)), rand_fixed()));
			else
				send_cmd(xform_cmd(rand_fixed(), rand_fixed(), rand_fixed(), rand_fixed()));
		end
		cmd_ch.valid = 1'b0;

		// drain: the watchdog covers a result that never shows up
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
design/mvt_pkg.sv
design/mvt_in_if.sv
design/mvt_out_if.sv
design/mvt_lane.sv
design/mvt_merge.sv
design/matrix_vector_transform_unit.sv
bench/mvt_tb_pkg.sv
bench/tb_top.sv
